>>> rtl/core/pll_pkg.sv
// Shared constants and types for the pooled linked list engine.
`timescale 1ns / 1ps

package pll_pkg;

  // Field widths of the command and response words
  localparam int KindWidth   = 3;
  localparam int PosWidth    = 6;
  localparam int DataWidth   = 32;
  localparam int LenOutWidth = 6;

  // Pool size default and the cap on results of one dump
  localparam int PoolNodesDefault = 32;
  localparam int MaxResults       = 32;

  // Operation codes
  localparam logic [KindWidth-1:0] KindInsert = 3'd0;
  localparam logic [KindWidth-1:0] KindErase  = 3'd1;
  localparam logic [KindWidth-1:0] KindPush   = 3'd2;
  localparam logic [KindWidth-1:0] KindPop    = 3'd3;
  localparam logic [KindWidth-1:0] KindDump   = 3'd4;

  // Write enables that go to every node cell
  typedef struct packed {
    logic next_we;
    logic value_we;
  } wr_en_t;

endpackage

>>> rtl/core/pll_cell.sv
// One pool node: next pointer and value, with a daisy-chained read path.
`timescale 1ns / 1ps

module pll_cell #(
  parameter int POOL_NODES = pll_pkg::PoolNodesDefault,
  parameter int CELL_INDEX = 0,
  parameter int IDX_W      = $clog2(POOL_NODES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [IDX_W-1:0]              wr_addr,
  input  pll_pkg::wr_en_t               wr_en,
  input  logic [IDX_W-1:0]              next_wdata,
  input  logic [pll_pkg::DataWidth-1:0] value_wdata,
  input  logic [IDX_W-1:0]              rd_addr,
  input  logic [IDX_W-1:0]              next_in,
  input  logic [pll_pkg::DataWidth-1:0] value_in,
  output logic [IDX_W-1:0]              next_out,
  output logic [pll_pkg::DataWidth-1:0] value_out
);

  localparam int NextInit = (CELL_INDEX + 1) % POOL_NODES;

  logic [IDX_W-1:0]              next_ptr;
  logic [pll_pkg::DataWidth-1:0] data;
  logic                          wr_hit;
  logic                          rd_hit;

  assign wr_hit = (wr_addr == IDX_W'(CELL_INDEX));
  assign rd_hit = (rd_addr == IDX_W'(CELL_INDEX));

  // Pointer: reset threads the whole pool into the free list
  always_ff @(posedge clk) begin
    if (rst) begin
      next_ptr <= IDX_W'(NextInit);
    end else if (wr_en.next_we && wr_hit) begin
      next_ptr <= next_wdata;
    end
  end

  // Value: written on insert and push only
  always_ff @(posedge clk) begin
    if (wr_en.value_we && wr_hit) begin
      data <= value_wdata;
    end
  end

  // Merge this node into the read chain when addressed
  assign next_out  = next_in  | (rd_hit ? next_ptr : '0);
  assign value_out = value_in | (rd_hit ? data : '0);

endmodule

>>> rtl/core/pll_cell_row.sv
// Row of node cells forming the pool, read through a chain from cell to cell.
`timescale 1ns / 1ps

module pll_cell_row #(
  parameter int POOL_NODES = pll_pkg::PoolNodesDefault,
  parameter int IDX_W      = $clog2(POOL_NODES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [IDX_W-1:0]              wr_addr,
  input  pll_pkg::wr_en_t               wr_en,
  input  logic [IDX_W-1:0]              next_wdata,
  input  logic [pll_pkg::DataWidth-1:0] value_wdata,
  input  logic [IDX_W-1:0]              rd_addr,
  output logic [IDX_W-1:0]              rd_next,
  output logic [pll_pkg::DataWidth-1:0] rd_value
);

  logic [IDX_W-1:0]              next_chain  [POOL_NODES+1];
  logic [pll_pkg::DataWidth-1:0] value_chain [POOL_NODES+1];

  // Chain starts empty; the addressed cell drops its word in
  assign next_chain[0]  = '0;
  assign value_chain[0] = '0;

  for (genvar i = 0; i < POOL_NODES; i++) begin : g_node
    pll_cell #(
      .POOL_NODES (POOL_NODES),
      .CELL_INDEX (i),
      .IDX_W      (IDX_W)
    ) u_node (
      .clk         (clk),
      .rst         (rst),
      .wr_addr     (wr_addr),
      .wr_en       (wr_en),
      .next_wdata  (next_wdata),
      .value_wdata (value_wdata),
      .rd_addr     (rd_addr),
      .next_in     (next_chain[i]),
      .value_in    (value_chain[i]),
      .next_out    (next_chain[i+1]),
      .value_out   (value_chain[i+1])
    );
  end

  assign rd_next  = next_chain[POOL_NODES];
  assign rd_value = value_chain[POOL_NODES];

endmodule

>>> rtl/core/pooled_linked_list_engine_unit.sv
// Pooled linked list engine: one singly linked list in a fixed node pool.
// Usage: the command channel (cmd_valid/cmd_stall) carries kind, position and
// value; a word is taken when cmd_valid is high and cmd_stall is low. Kinds are
// insert, erase, push back, pop back and dump. The response channel
// (rsp_valid/rsp_stall) returns ok, item_value, empty_res, last, length_after.
// Every command gives one response word, except a dump of a non-empty list,
// which gives one word per element (at most 32) with last on the final one.
// Timing: one command at a time. The pointer walk takes one hop per cycle
// through the node cell chain.
// Reset (synchronous, active high) empties the list and threads every pool
// node into the free list; node values are undefined until written.
// A stalled response holds in the output register; the engine can take the
// next command while it waits, but does not load a new response until the
// held word is taken.
`timescale 1ns / 1ps

module pooled_linked_list_engine_unit #(
  parameter int POOL_NODES = pll_pkg::PoolNodesDefault
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  logic [pll_pkg::KindWidth-1:0]        kind,
  input  logic [pll_pkg::PosWidth-1:0]         position,
  input  logic signed [pll_pkg::DataWidth-1:0] value,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output logic                                 ok,
  output logic signed [pll_pkg::DataWidth-1:0] item_value,
  output logic                                 empty_res,
  output logic                                 last,
  output logic [pll_pkg::LenOutWidth-1:0]      length_after
);

  localparam int IDX_W = $clog2(POOL_NODES);
  localparam int LEN_W = $clog2(POOL_NODES + 1);
  localparam int CNT_W = (LEN_W > pll_pkg::PosWidth) ? LEN_W : pll_pkg::PosWidth;
  localparam int HalfNodes = POOL_NODES / 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_INS_TAKE,
    S_INS_LINK,
    S_INS_HOOK,
    S_DEL_HEAD,
    S_DEL_FETCH,
    S_DEL_UNLINK,
    S_DEL_FREE,
    S_DUMP,
    S_RESP
  } state_t;

  state_t                          state;
  logic [pll_pkg::KindWidth-1:0]   kind_r;
  logic [pll_pkg::DataWidth-1:0]   val_r;
  logic                            at_head;
  logic                            ok_r;
  logic                            empty_r;
  logic [IDX_W-1:0]                free_head;
  logic [IDX_W-1:0]                list_head;
  logic [LEN_W-1:0]                list_length;
  logic [IDX_W-1:0]                walk_ptr;
  logic [IDX_W-1:0]                node;
  logic [CNT_W-1:0]                count;

  logic [CNT_W-1:0]                pos_x;
  logic [CNT_W-1:0]                len_x;
  logic                            acc_ok;
  logic                            acc_head;
  logic [CNT_W-1:0]                acc_hops;
  logic                            rsp_free;
  logic                            rsp_load;

  logic [IDX_W-1:0]                rd_addr;
  logic [IDX_W-1:0]                rd_next;
  logic [pll_pkg::DataWidth-1:0]   rd_value;
  logic [IDX_W-1:0]                wr_addr;
  pll_pkg::wr_en_t                 wr_en;
  logic [IDX_W-1:0]                next_wdata;

  // Pick the splice step that follows the pointer walk
  function automatic state_t resume_state(input logic [pll_pkg::KindWidth-1:0] k,
                                          input logic head);
    state_t s;
    case (k) inside
      pll_pkg::KindInsert, pll_pkg::KindPush: s = S_INS_TAKE;
      pll_pkg::KindErase, pll_pkg::KindPop:   s = head ? S_DEL_HEAD : S_DEL_FETCH;
      default:                                s = S_RESP;
    endcase
    return s;
  endfunction

  // Node pool
  pll_cell_row #(
    .POOL_NODES (POOL_NODES),
    .IDX_W      (IDX_W)
  ) u_row (
    .clk         (clk),
    .rst         (rst),
    .wr_addr     (wr_addr),
    .wr_en       (wr_en),
    .next_wdata  (next_wdata),
    .value_wdata (val_r),
    .rd_addr     (rd_addr),
    .rd_next     (rd_next),
    .rd_value    (rd_value)
  );

  assign cmd_stall = (state != S_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign rsp_load  = rsp_free && ((state == S_DUMP) || (state == S_RESP));

  // Decode the incoming command: legality, head case and walk length
  assign pos_x = CNT_W'(position);
  assign len_x = CNT_W'(list_length);

  always_comb begin
    acc_ok   = 1'b0;
    acc_head = 1'b0;
    acc_hops = '0;
    unique case (kind)
      pll_pkg::KindInsert: begin
        acc_ok   = (len_x < CNT_W'(POOL_NODES)) && (pos_x <= len_x);
        acc_head = (pos_x == '0);
        acc_hops = acc_head ? '0 : pos_x - CNT_W'(1);
      end
      pll_pkg::KindErase: begin
        acc_ok   = (pos_x < len_x);
        acc_head = (pos_x == '0);
        acc_hops = acc_head ? '0 : pos_x - CNT_W'(1);
      end
      pll_pkg::KindPush: begin
        acc_ok   = (len_x < CNT_W'(HalfNodes));
        acc_head = (len_x == '0);
        acc_hops = acc_head ? '0 : len_x - CNT_W'(1);
      end
      pll_pkg::KindPop: begin
        acc_ok   = (len_x != '0);
        acc_head = (len_x == CNT_W'(1));
        acc_hops = (len_x < CNT_W'(2)) ? '0 : len_x - CNT_W'(2);
      end
      pll_pkg::KindDump: begin
        acc_ok   = 1'b1;
        acc_head = (len_x == '0);
        acc_hops = (len_x > CNT_W'(pll_pkg::MaxResults)) ?
                   CNT_W'(pll_pkg::MaxResults) : len_x;
      end
      default: begin
        acc_ok = 1'b0;
      end
    endcase
  end

  // Drive the pool read and write ports from the current step
  always_comb begin
    rd_addr    = walk_ptr;
    wr_addr    = node;
    wr_en      = '0;
    next_wdata = free_head;
    unique case (state)
      S_INS_TAKE: begin
        rd_addr = free_head;
      end
      S_INS_LINK: begin
        wr_addr        = node;
        wr_en.value_we = 1'b1;
        wr_en.next_we  = !((kind_r == pll_pkg::KindPush) && at_head);
        next_wdata     = at_head ? list_head : rd_next;
      end
      S_INS_HOOK: begin
        wr_addr       = walk_ptr;
        wr_en.next_we = 1'b1;
        next_wdata    = node;
      end
      S_DEL_HEAD: begin
        rd_addr       = list_head;
        wr_addr       = list_head;
        wr_en.next_we = 1'b1;
        next_wdata    = free_head;
      end
      S_DEL_UNLINK: begin
        rd_addr       = node;
        wr_addr       = walk_ptr;
        wr_en.next_we = 1'b1;
        next_wdata    = (kind_r == pll_pkg::KindPop) ? '0 : rd_next;
      end
      S_DEL_FREE: begin
        wr_addr       = node;
        wr_en.next_we = 1'b1;
        next_wdata    = free_head;
      end
      default: begin
        rd_addr = walk_ptr;
      end
    endcase
  end

  // Sequencer, list registers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_head   <= '0;
      list_head   <= '0;
      list_length <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // drop the response word once taken, unless a new one loads now
      if (!rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            kind_r   <= kind;
            val_r    <= value;
            at_head  <= acc_head;
            ok_r     <= acc_ok;
            empty_r  <= (kind == pll_pkg::KindDump) && acc_head;
            walk_ptr <= list_head;
            count    <= acc_hops;
            if (!acc_ok) begin
              state <= S_RESP;
            end else if (kind == pll_pkg::KindDump) begin
              state <= acc_head ? S_RESP : S_DUMP;
            end else if (acc_hops == '0) begin
              state <= resume_state(kind, acc_head);
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          walk_ptr <= rd_next;
          count    <= count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state <= resume_state(kind_r, at_head);
          end
        end
        S_INS_TAKE: begin
          node      <= free_head;
          free_head <= rd_next;
          state     <= S_INS_LINK;
        end
        S_INS_LINK: begin
          if (at_head) begin
            list_head   <= node;
            list_length <= list_length + LEN_W'(1);
            state       <= S_RESP;
          end else begin
            state <= S_INS_HOOK;
          end
        end
        S_INS_HOOK: begin
          list_length <= list_length + LEN_W'(1);
          state       <= S_RESP;
        end
        S_DEL_HEAD: begin
          free_head   <= list_head;
          list_head   <= (kind_r == pll_pkg::KindErase) ? rd_next : '0;
          list_length <= list_length - LEN_W'(1);
          state       <= S_RESP;
        end
        S_DEL_FETCH: begin
          node  <= rd_next;
          state <= S_DEL_UNLINK;
        end
        S_DEL_UNLINK: begin
          state <= S_DEL_FREE;
        end
        S_DEL_FREE: begin
          free_head   <= node;
          list_length <= list_length - LEN_W'(1);
          state       <= S_RESP;
        end
        S_DUMP: begin
          // emit one element per free response slot
          if (rsp_free) begin
            rsp_valid    <= 1'b1;
            ok           <= 1'b1;
            item_value   <= rd_value;
            empty_res    <= 1'b0;
            last         <= (count == CNT_W'(1));
            length_after <= pll_pkg::LenOutWidth'(list_length);
            walk_ptr     <= rd_next;
            count        <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_RESP: begin
          if (rsp_free) begin
            rsp_valid    <= 1'b1;
            ok           <= ok_r;
            item_value   <= '0;
            empty_res    <= empty_r;
            last         <= 1'b1;
            length_after <= pll_pkg::LenOutWidth'(list_length);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Length never exceeds the pool
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    list_length <= LEN_W'(POOL_NODES))
    else $error("list length beyond pool size");

  // A walk always has hops left to take
  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> count != '0)
    else $error("pointer walk with zero hop count");

  // Length only moves while a command is in flight
  a_idle_len: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |=> $stable(list_length))
    else $error("list length changed while idle");

  // Free list and list never share their head node while idle with a list neither empty nor full
  a_heads_apart: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && list_length != '0 && list_length != LEN_W'(POOL_NODES))
      |-> free_head != list_head)
    else $error("free head and list head coincide");

endmodule

>>> sim/tb_pooled_linked_list_engine_unit.sv
// Self-checking testbench for the pooled linked list engine with a node pool model.
`timescale 1ns / 1ps

module tb_pooled_linked_list_engine_unit;

  localparam int Pool          = pll_pkg::PoolNodesDefault;
  localparam int PtrWidth      = $clog2(Pool);
  localparam int WatchdogLimit = 3000;
  localparam int TailCycles    = 40;
  localparam int ReportLimit   = 10;

  // One response word as the engine returns it
  typedef struct packed {
    logic                            ok;
    logic [pll_pkg::DataWidth-1:0]   item_value;
    logic                            empty_res;
    logic                            last;
    logic [pll_pkg::LenOutWidth-1:0] length_after;
  } rsp_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                 cmd_valid = 1'b0;
  logic                                 cmd_stall;
  logic [pll_pkg::KindWidth-1:0]        kind      = '0;
  logic [pll_pkg::PosWidth-1:0]         position  = '0;
  logic signed [pll_pkg::DataWidth-1:0] value     = '0;

  logic                                 rsp_valid;
  logic                                 rsp_stall = 1'b0;
  logic                                 ok;
  logic signed [pll_pkg::DataWidth-1:0] item_value;
  logic                                 empty_res;
  logic                                 last;
  logic [pll_pkg::LenOutWidth-1:0]      length_after;

  pooled_linked_list_engine_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .kind        (kind),
    .position    (position),
    .value       (value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .ok          (ok),
    .item_value  (item_value),
    .empty_res   (empty_res),
    .last        (last),
    .length_after(length_after)
  );

  always #10 clk = ~clk;

  // Shadow copy of the pool, free list and list
  logic [PtrWidth-1:0]           pool_next [Pool];
  logic [pll_pkg::DataWidth-1:0] pool_data [Pool];
  logic [PtrWidth-1:0]           free_ptr;
  logic [PtrWidth-1:0]           head_ptr;
  int unsigned                   list_len;

  rsp_word_t rsp_words_due[$];
  rsp_word_t want_word;
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;
  bit        cmd_idle_en    = 1'b1;
  bit        rsp_idle_en    = 1'b1;

  function automatic rsp_word_t rsp_word(logic okb, logic [pll_pkg::DataWidth-1:0] v,
                                         logic emp, logic lst);
    rsp_word_t w;
    w.ok           = okb;
    w.item_value   = v;
    w.empty_res    = emp;
    w.last         = lst;
    w.length_after = list_len[pll_pkg::LenOutWidth-1:0];
    return w;
  endfunction

  function automatic logic [PtrWidth-1:0] node_at(int unsigned pos);
    logic [PtrWidth-1:0] j;
    j = head_ptr;
    for (int unsigned k = 0; k < pos; k++) j = pool_next[j];
    return j;
  endfunction

  function automatic void clear_list_model();
    for (int i = 0; i < Pool; i++) begin
      pool_next[i] = PtrWidth'((i + 1) % Pool);
      pool_data[i] = '0;
    end
    free_ptr = '0;
    head_ptr = '0;
    list_len = 0;
  endfunction

  // Apply one command to the shadow list and queue the words it must produce
  function automatic void apply_list_op(logic [pll_pkg::KindWidth-1:0] k,
                                        logic [pll_pkg::PosWidth-1:0] p,
                                        logic [pll_pkg::DataWidth-1:0] v);
    logic [PtrWidth-1:0] n;
    logic [PtrWidth-1:0] j;
    logic [PtrWidth-1:0] victim;
    logic                okb;
    int unsigned         cnt;
    okb = 1'b0;
    if (k == pll_pkg::KindDump) begin
      if (list_len == 0) begin
        rsp_words_due.push_back(rsp_word(1'b1, '0, 1'b1, 1'b1));
      end else begin
        cnt = (list_len > pll_pkg::MaxResults) ? pll_pkg::MaxResults : list_len;
        j = head_ptr;
        for (int unsigned i = 0; i < cnt; i++) begin
          rsp_words_due.push_back(rsp_word(1'b1, pool_data[j], 1'b0, (i + 1 == cnt)));
          j = pool_next[j];
        end
      end
      return;
    end
    case (k)
      pll_pkg::KindInsert: begin
        if (list_len < Pool && p <= list_len) begin
          n = free_ptr;
          free_ptr = pool_next[n];
          pool_data[n] = v;
          if (p == 0) begin
            pool_next[n] = head_ptr;
            head_ptr = n;
          end else begin
            j = node_at(p - 1);
            pool_next[n] = pool_next[j];
            pool_next[j] = n;
          end
          list_len++;
          okb = 1'b1;
        end
      end
      pll_pkg::KindErase: begin
        if (p < list_len) begin
          if (p == 0) begin
            victim = head_ptr;
            head_ptr = pool_next[victim];
          end else begin
            j = node_at(p - 1);
            victim = pool_next[j];
            pool_next[j] = pool_next[victim];
          end
          pool_next[victim] = free_ptr;
          free_ptr = victim;
          list_len--;
          okb = 1'b1;
        end
      end
      pll_pkg::KindPush: begin
        if (list_len < Pool / 2) begin
          n = free_ptr;
          free_ptr = pool_next[n];
          pool_data[n] = v;
          if (list_len == 0) begin
            head_ptr = n;
          end else begin
            j = node_at(list_len - 1);
            pool_next[n] = pool_next[j];
            pool_next[j] = n;
          end
          list_len++;
          okb = 1'b1;
        end
      end
      pll_pkg::KindPop: begin
        if (list_len > 0) begin
          if (list_len == 1) begin
            pool_next[head_ptr] = free_ptr;
            free_ptr = head_ptr;
            head_ptr = '0;
          end else begin
            j = node_at(list_len - 2);
            victim = pool_next[j];
            pool_next[victim] = free_ptr;
            free_ptr = victim;
            pool_next[j] = '0;
          end
          list_len--;
          okb = 1'b1;
        end
      end
      default: ;
    endcase
    rsp_words_due.push_back(rsp_word(okb, '0, 1'b0, 1'b1));
  endfunction

  function automatic logic [pll_pkg::DataWidth-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Present one command word, hold it until taken, then predict its result
  task automatic send_list_cmd(input logic [pll_pkg::KindWidth-1:0] k,
                               input logic [pll_pkg::PosWidth-1:0] p,
                               input logic [pll_pkg::DataWidth-1:0] v);
    if (cmd_idle_en && $urandom_range(0, 3) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    kind      <= k;
    position  <= p;
    value     <= v;
    forever begin
      @(posedge clk);
      if (cmd_stall == 1'b0) break;
    end
    apply_list_op(k, p, v);
  endtask

  // Drop valid and hold off until every queued word has come back
  task automatic wait_rsp_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (rsp_words_due.size() != 0);
  endtask

  task automatic apply_reset();
    clear_list_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  endtask

  // Refusals and dump on an empty list, plus the unused kinds
  task automatic test_empty_list();
    send_list_cmd(pll_pkg::KindPop, 6'd0, 32'h0);
    send_list_cmd(pll_pkg::KindErase, 6'd0, 32'h0);
    send_list_cmd(pll_pkg::KindInsert, 6'd1, 32'h5555_AAAA);
    send_list_cmd(pll_pkg::KindDump, 6'd63, 32'hFFFF_FFFF);
    send_list_cmd(3'd5, 6'd0, 32'h1);
    send_list_cmd(3'd6, 6'd42, 32'h8000_0000);
    send_list_cmd(3'd7, 6'd21, 32'h7FFF_FFFF);
  endtask

  // Insert and erase at head, middle and tail with extreme values
  task automatic test_edit_positions();
    send_list_cmd(pll_pkg::KindPush, 6'd0, 32'h7FFF_FFFF);
    send_list_cmd(pll_pkg::KindPush, 6'd0, 32'h8000_0000);
    send_list_cmd(pll_pkg::KindInsert, 6'd0, 32'h0000_0000);
    send_list_cmd(pll_pkg::KindInsert, 6'd3, 32'hFFFF_FFFF);
    send_list_cmd(pll_pkg::KindInsert, 6'd2, 32'h1234_5678);
    send_list_cmd(pll_pkg::KindInsert, 6'd9, 32'hDEAD_BEEF);
    send_list_cmd(pll_pkg::KindDump, 6'd0, 32'h0);
    send_list_cmd(pll_pkg::KindErase, 6'd4, 32'h0);
    send_list_cmd(pll_pkg::KindErase, 6'd0, 32'h0);
    send_list_cmd(pll_pkg::KindErase, 6'd1, 32'h0);
    send_list_cmd(pll_pkg::KindErase, 6'd5, 32'h0);
    send_list_cmd(pll_pkg::KindDump, 6'd0, 32'h0);
    send_list_cmd(pll_pkg::KindPop, 6'd0, 32'h0);
    send_list_cmd(pll_pkg::KindPop, 6'd0, 32'h0);
    send_list_cmd(pll_pkg::KindPop, 6'd0, 32'h0);
    send_list_cmd(pll_pkg::KindDump, 6'd0, 32'h0);
  endtask

  // Push to the half-pool limit, insert to a full pool, dump all of it
  task automatic test_fill_pool();
    while (list_len < Pool / 2) begin
      send_list_cmd(pll_pkg::KindPush, pll_pkg::PosWidth'($urandom_range(0, 63)),
                    pick_value());
    end
    send_list_cmd(pll_pkg::KindPush, 6'd0, pick_value());
    while (list_len < Pool) begin
      send_list_cmd(pll_pkg::KindInsert, pll_pkg::PosWidth'($urandom_range(0, list_len)),
                    pick_value());
    end
    send_list_cmd(pll_pkg::KindInsert, 6'd0, pick_value());
    send_list_cmd(pll_pkg::KindDump, 6'd0, 32'h0);
    send_list_cmd(pll_pkg::KindErase, pll_pkg::PosWidth'(Pool), 32'h0);
    send_list_cmd(pll_pkg::KindPush, 6'd0, pick_value());
  endtask

  // Random well-formed commands, biased to grow or shrink, with some noise
  task automatic test_random_mix(input int n_items, input int grow_pct);
    int                            r;
    logic [pll_pkg::KindWidth-1:0] k;
    logic [pll_pkg::PosWidth-1:0]  p;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      p = pll_pkg::PosWidth'($urandom_range(0, 63));
      if (r < 8) begin
        k = pll_pkg::KindWidth'($urandom_range(0, 7));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          k = pll_pkg::KindDump;
        end else if (r < 12 + grow_pct) begin
          k = $urandom_range(0, 1) ? pll_pkg::KindInsert : pll_pkg::KindPush;
          if (k == pll_pkg::KindInsert) p = pll_pkg::PosWidth'($urandom_range(0, list_len));
        end else begin
          k = $urandom_range(0, 1) ? pll_pkg::KindErase : pll_pkg::KindPop;
          if (k == pll_pkg::KindErase) begin
            p = (list_len == 0) ? '0 : pll_pkg::PosWidth'($urandom_range(0, list_len - 1));
          end
        end
      end
      send_list_cmd(k, p, pick_value());
    end
  endtask

  // Response side stall bursts
  always begin
    if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
      rsp_stall <= 1'b1;
      repeat ($urandom_range(1, 14)) @(posedge clk);
      rsp_stall <= 1'b0;
    end
    @(posedge clk);
  end

  // Compare each taken response word with the oldest expected one
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
      if (rsp_words_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
          $display("unexpected word: ok=%0b item_value=%h empty_res=%0b last=%0b len=%0d",
                   ok, item_value, empty_res, last, length_after);
      end else begin
        want_word = rsp_words_due.pop_front();
        if (ok !== want_word.ok || item_value !== want_word.item_value ||
            empty_res !== want_word.empty_res || last !== want_word.last ||
            length_after !== want_word.length_after) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("mismatch: expected ok=%0b item_value=%h empty_res=%0b last=%0b len=%0d",
                     want_word.ok, want_word.item_value, want_word.empty_res,
                     want_word.last, want_word.length_after);
            $display("          actual   ok=%0b item_value=%h empty_res=%0b last=%0b len=%0d",
                     ok, item_value, empty_res, last, length_after);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_stall == 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    apply_reset();
    test_empty_list();
    test_edit_positions();
    wait_rsp_drained();
    test_fill_pool();
    test_random_mix(35, 10);
    test_random_mix(35, 70);
    wait_rsp_drained();
    test_random_mix(15, 35);
    // last stretch runs with both sides always ready
    cmd_idle_en = 1'b0;
    rsp_idle_en = 1'b0;
    test_random_mix(25, 45);
    wait_rsp_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && rsp_words_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pll_pkg.sv
rtl/core/pll_cell.sv
rtl/core/pll_cell_row.sv
rtl/core/pooled_linked_list_engine_unit.sv
sim/tb_pooled_linked_list_engine_unit.sv
